// File: design/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types and operation codes for the four-bit CPU execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package fbc_pkg;

	localparam int unsigned DATA_W  = 4;
	localparam int unsigned INSTR_W = 8;
	localparam int unsigned IMM_W   = 3;

	localparam int unsigned BIT_JUMP  = 7;
	localparam int unsigned BIT_CJUMP = 6;

	// instruction bits 5:2
	localparam logic [3:0] OP_ADD_A = 4'h0;
	localparam logic [3:0] OP_SUB_A = 4'h1;
	localparam logic [3:0] OP_LDI_A = 4'h2;
	localparam logic [3:0] OP_LDI_AH = 4'h3;
	localparam logic [3:0] OP_ADD_B = 4'h4;
	localparam logic [3:0] OP_SUB_B = 4'h5;
	localparam logic [3:0] OP_LDI_B = 4'h6;
	localparam logic [3:0] OP_LDI_BH = 4'h7;
	localparam logic [3:0] OP_OUT_A = 4'h8;

	typedef logic [DATA_W-1:0] data_t;

	typedef struct packed {
		data_t acc_a;
		data_t acc_b;
		data_t out_reg;
		logic  carry;
		logic  overflow;
	} arch_state_t;

endpackage : fbc_pkg

`default_nettype wire

// File: design/fbc_exec.sv
// ----------------------------------------------------------------------------
// fbc_exec
// Decode and execute one instruction against the current machine state.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_exec #(
	parameter int unsigned PC_WIDTH = 4
) (
	input  wire logic [fbc_pkg::INSTR_W-1:0] instr,
	input  wire fbc_pkg::arch_state_t        state,
	input  wire logic [PC_WIDTH-1:0]         pc,
	output fbc_pkg::arch_state_t             state_nxt,
	output logic [PC_WIDTH-1:0]              pc_nxt,
	output logic                             wrote
);

	logic [fbc_pkg::IMM_W-1:0]  imm;
	logic [3:0]                 op;
	logic [fbc_pkg::DATA_W:0]   sum;
	logic [fbc_pkg::DATA_W:0]   diff;
	fbc_pkg::data_t             add_r;
	fbc_pkg::data_t             sub_r;
	logic                       add_c;
	logic                       add_v;
	logic                       sub_c;
	logic                       sub_v;
	logic                       jump;
	logic                       sa;
	logic                       sb;

	assign imm  = instr[fbc_pkg::IMM_W-1:0];
	assign op   = instr[5:2];
	assign sa   = state.acc_a[fbc_pkg::DATA_W-1];
	assign sb   = state.acc_b[fbc_pkg::DATA_W-1];

	assign sum   = {1'b0, state.acc_a} + {1'b0, state.acc_b};
	assign diff  = {1'b0, state.acc_a} - {1'b0, state.acc_b};
	assign add_r = sum[fbc_pkg::DATA_W-1:0];
	assign sub_r = diff[fbc_pkg::DATA_W-1:0];
	assign add_c = sum[fbc_pkg::DATA_W];
	assign sub_c = diff[fbc_pkg::DATA_W];
	assign add_v = (sa == sb) && (sa != add_r[fbc_pkg::DATA_W-1]);
	assign sub_v = (sa != sb) && (sa != sub_r[fbc_pkg::DATA_W-1]);

	always_comb begin
		state_nxt = state;
		wrote     = 1'b0;
		jump      = 1'b0;
		priority if (instr[fbc_pkg::BIT_JUMP]) begin
			jump = 1'b1;
		end else if (instr[fbc_pkg::BIT_CJUMP]) begin
			jump = state.carry;
		end else begin
			unique case (op)
				fbc_pkg::OP_ADD_A: begin
					state_nxt.acc_a    = add_r;
					state_nxt.carry    = add_c;
					state_nxt.overflow = add_v;
				end
				fbc_pkg::OP_ADD_B: begin
					state_nxt.acc_b    = add_r;
					state_nxt.carry    = add_c;
					state_nxt.overflow = add_v;
				end
				fbc_pkg::OP_SUB_A: begin
					state_nxt.acc_a    = sub_r;
					state_nxt.carry    = sub_c;
					state_nxt.overflow = sub_v;
				end
				fbc_pkg::OP_SUB_B: begin
					state_nxt.acc_b    = sub_r;
					state_nxt.carry    = sub_c;
					state_nxt.overflow = sub_v;
				end
				fbc_pkg::OP_OUT_A: begin
					state_nxt.out_reg = state.acc_a;
					wrote             = 1'b1;
				end
				fbc_pkg::OP_LDI_A, fbc_pkg::OP_LDI_AH: begin
					state_nxt.acc_a = fbc_pkg::DATA_W'(imm);
				end
				fbc_pkg::OP_LDI_B, fbc_pkg::OP_LDI_BH: begin
					state_nxt.acc_b = fbc_pkg::DATA_W'(imm);
				end
				default: begin
				end
			endcase
		end

		if (jump) begin
			pc_nxt             = PC_WIDTH'(imm);
			state_nxt.carry    = 1'b0;
			state_nxt.overflow = 1'b0;
		end else begin
			pc_nxt = pc + PC_WIDTH'(1);
		end
	end

endmodule : fbc_exec

`default_nettype wire

// File: design/four_bit_cpu_execute.sv
// ----------------------------------------------------------------------------
// four_bit_cpu_execute
// Path: an accepted instruction is captured in the input register, then
// executed into the machine state and result register, from which the
// result is presented. Throughput: one instruction per cycle, set by the
// single execute stage, while out_ready does not stall the result register.
// Reset: asynchronous, clears A, B, O, flags, program counter and both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module four_bit_cpu_execute #(
	parameter int unsigned PC_WIDTH = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [fbc_pkg::INSTR_W-1:0]   instr_bits,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [3:0]                         next_pc,
	output logic [fbc_pkg::DATA_W-1:0]         reg_a_value,
	output logic [fbc_pkg::DATA_W-1:0]         reg_b_value,
	output logic [fbc_pkg::DATA_W-1:0]         out_value,
	output logic                               out_written,
	output logic                               carry_flag,
	output logic                               overflow_flag
);

	logic [fbc_pkg::INSTR_W-1:0] instr_s1;
	logic                        valid_s1;
	logic                        valid_s2;
	logic                        wrote_s2;
	fbc_pkg::arch_state_t        state_q;
	fbc_pkg::arch_state_t        state_nxt;
	logic [PC_WIDTH-1:0]         pc_q;
	logic [PC_WIDTH-1:0]         pc_nxt;
	logic                        wrote;
	logic                        advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	fbc_exec #(
		.PC_WIDTH(PC_WIDTH)
	) u_exec (
		.instr    (instr_s1),
		.state    (state_q),
		.pc       (pc_q),
		.state_nxt(state_nxt),
		.pc_nxt   (pc_nxt),
		.wrote    (wrote)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			instr_s1 <= instr_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			wrote_s2 <= 1'b0;
			state_q  <= '0;
			pc_q     <= '0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
			wrote_s2 <= wrote;
			state_q  <= state_nxt;
			pc_q     <= pc_nxt;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	assign out_valid     = valid_s2;
	assign next_pc       = 4'(pc_q);
	assign reg_a_value   = state_q.acc_a;
	assign reg_b_value   = state_q.acc_b;
	assign out_value     = state_q.out_reg;
	assign out_written   = wrote_s2;
	assign carry_flag    = state_q.carry;
	assign overflow_flag = state_q.overflow;

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("execute stage did not present its result");

	a_out_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && wrote_s2) |-> (state_q.out_reg == state_q.acc_a))
		else $error("O differs from A after O = A");

	a_jump_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && instr_s1[fbc_pkg::BIT_JUMP]) |=> (!state_q.carry && !state_q.overflow))
		else $error("jump left a flag set");

	a_pc_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !instr_s1[fbc_pkg::BIT_JUMP] && !instr_s1[fbc_pkg::BIT_CJUMP])
		|=> (pc_q == PC_WIDTH'($past(pc_q) + PC_WIDTH'(1))))
		else $error("program counter did not advance by one");

endmodule : four_bit_cpu_execute

`default_nettype wire
